@@ src/sbcd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and codes of the stereo bit crusher and decimator.
// Depends on nothing; every other file imports it.
package sbcd_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int MAX_PERIOD  = 100;

  localparam int PHASE_W = 23;
  localparam int FRAC_W  = 17;
  localparam int ONE_Q16 = 65536;

  localparam logic [PHASE_W-1:0] PERIOD_MIN = PHASE_W'(ONE_Q16);
  localparam logic [PHASE_W-1:0] PERIOD_MAX = PHASE_W'(MAX_PERIOD * ONE_Q16);
  localparam logic [PHASE_W-1:0] PHASE_SAT  = '1;
  localparam logic [FRAC_W-1:0]  FRAC_ONE   = FRAC_W'(ONE_Q16);

  localparam int LEVELS_W = 31;
  localparam int RECIP_W  = 32;
  localparam int WET_W    = 17;

  localparam int QUANT_W      = 24;
  localparam int MUL_A_W      = (SAMPLE_BITS + 2 > QUANT_W + 1) ? SAMPLE_BITS + 2 : QUANT_W + 1;
  localparam int MUL_B_W      = 32;
  localparam int MUL_DIGITS   = MUL_B_W / 2;
  localparam int PROD_W       = MUL_A_W + MUL_B_W;
  localparam int CNT_W        = $clog2(MUL_DIGITS + 1);
  localparam int ROUND_SHIFT  = 16;
  localparam int LEVEL_SHIFT  = SAMPLE_BITS + 7;
  localparam int RECIP_SHIFT  = 33 - SAMPLE_BITS;
  localparam int CRUSH_W      = PROD_W - RECIP_SHIFT;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] MAG_LIMIT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECIM_PERIOD = 3'd0,
    REG_QUANT_ENABLE = 3'd1,
    REG_QUANT_LEVELS = 3'd2,
    REG_QUANT_RECIP  = 3'd3,
    REG_WET_MIX      = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_INTERP,
    OP_LEVEL,
    OP_RECIP,
    OP_MIX
  } mul_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INTERP,
    ST_HOLD,
    ST_QLEVEL,
    ST_QRECIP,
    ST_QFIN,
    ST_MIX,
    ST_OUT
  } seq_state_t;

  typedef struct packed {
    logic [PHASE_W-1:0]  decim_period;
    logic                quant_enable;
    logic [LEVELS_W-1:0] quant_levels;
    logic [RECIP_W-1:0]  quant_recip;
    logic [WET_W-1:0]    wet_mix;
  } cfg_t;

  typedef struct packed {
    logic    x_load;
    mul_op_t op;
    logic    mul_load;
    logic    mul_step;
    logic    hold_wr;
    logic    held_upd;
    logic    crush_wr;
    logic    quant;
  } lane_ctl_t;

  typedef struct packed {
    logic [FRAC_W-1:0]   frac;
    logic [WET_W-1:0]    wet;
    logic [LEVELS_W-1:0] levels;
    logic [RECIP_W-1:0]  recip;
  } lane_coef_t;

endpackage

@@ src/sbcd_if.sv @@
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the sample request and the result request.
// Depends on sbcd_pkg for the sample type.
interface sbcd_in_if import sbcd_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t in_left;
  sample_t in_right;

  modport source (output valid, output in_left, output in_right, input ready);
  modport sink (input valid, input in_left, input in_right, output ready);
endinterface

interface sbcd_out_if import sbcd_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t out_left;
  sample_t out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink (input valid, input out_left, input out_right, output ready);
endinterface

@@ src/sbcd_regs.sv @@
`timescale 1ns / 1ps
// APB-style configuration register file of the crusher.
// Depends on sbcd_pkg for the register codes and the cfg_t bundle.
module sbcd_regs import sbcd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [PHASE_W-1:0]  decim_r, decim_nxt;
  logic                qen_r, qen_nxt;
  logic [LEVELS_W-1:0] levels_r, levels_nxt;
  logic [RECIP_W-1:0]  recip_r, recip_nxt;
  logic [WET_W-1:0]    wet_r, wet_nxt;
  logic                wr_en;
  cfg_reg_t            reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

  always_comb begin
    decim_nxt  = decim_r;
    qen_nxt    = qen_r;
    levels_nxt = levels_r;
    recip_nxt  = recip_r;
    wet_nxt    = wet_r;
    if (wr_en) begin
      case (reg_idx)
        REG_DECIM_PERIOD: decim_nxt  = pwdata[PHASE_W-1:0];
        REG_QUANT_ENABLE: qen_nxt    = pwdata[0];
        REG_QUANT_LEVELS: levels_nxt = pwdata[LEVELS_W-1:0];
        REG_QUANT_RECIP:  recip_nxt  = pwdata[RECIP_W-1:0];
        REG_WET_MIX:      wet_nxt    = pwdata[WET_W-1:0];
        default:          decim_nxt  = decim_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decim_r  <= PERIOD_MIN;
      qen_r    <= 1'b0;
      levels_r <= LEVELS_W'(256);
      recip_r  <= RECIP_W'(32'd16777216);
      wet_r    <= WET_W'(32768);
    end else begin
      decim_r  <= decim_nxt;
      qen_r    <= qen_nxt;
      levels_r <= levels_nxt;
      recip_r  <= recip_nxt;
      wet_r    <= wet_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DECIM_PERIOD: prdata = CFG_DATA_W'(decim_r);
      REG_QUANT_ENABLE: prdata = CFG_DATA_W'(qen_r);
      REG_QUANT_LEVELS: prdata = CFG_DATA_W'(levels_r);
      REG_QUANT_RECIP:  prdata = CFG_DATA_W'(recip_r);
      REG_WET_MIX:      prdata = CFG_DATA_W'(wet_r);
      default:          prdata = '0;
    endcase
  end

  assign cfg.decim_period = decim_r;
  assign cfg.quant_enable = qen_r;
  assign cfg.quant_levels = levels_r;
  assign cfg.quant_recip  = recip_r;
  assign cfg.wet_mix      = wet_r;

endmodule

@@ src/sbcd_mul.sv @@
`timescale 1ns / 1ps
// Radix-4 shift-add multiplier: signed multiplicand by unsigned multiplier,
// two multiplier bits per cycle while step is high. Depends on sbcd_pkg for its widths.
module sbcd_mul import sbcd_pkg::*; (
  input  logic                      clk,
  input  logic                      load,
  input  logic                      step,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic        [MUL_B_W-1:0] b,
  output logic signed [PROD_W-1:0]  prod
);

  logic signed [MUL_A_W-1:0]   a_r, a_nxt;
  logic signed [MUL_A_W+1:0]   a3_r, a3_nxt;
  logic signed [MUL_A_W-1:0]   hi_r, hi_nxt;
  logic        [MUL_B_W-1:0]   lo_r, lo_nxt;
  logic signed [MUL_A_W+1:0]   addend;
  logic signed [MUL_A_W+1:0]   sum;

  always_comb begin
    case (lo_r[1:0])
      2'd1:    addend = (MUL_A_W+2)'(a_r);
      2'd2:    addend = (MUL_A_W+2)'(a_r) <<< 1;
      2'd3:    addend = a3_r;
      default: addend = '0;
    endcase
    sum = (MUL_A_W+2)'(hi_r) + addend;
  end

  always_comb begin
    a_nxt  = a_r;
    a3_nxt = a3_r;
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    if (load) begin
      a_nxt  = a;
      a3_nxt = (MUL_A_W+2)'(a) + ((MUL_A_W+2)'(a) <<< 1);
      hi_nxt = '0;
      lo_nxt = b;
    end else if (step) begin
      hi_nxt = sum[MUL_A_W+1:2];
      lo_nxt = {sum[1:0], lo_r[MUL_B_W-1:2]};
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= a_nxt;
    a3_r <= a3_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign prod = {hi_r, lo_r};

endmodule

@@ src/sbcd_lane.sv @@
`timescale 1ns / 1ps
// One audio channel: sample history, held value, crusher and wet/dry mix,
// all products taken on one serial multiplier. Depends on sbcd_pkg, sbcd_mul.
module sbcd_lane import sbcd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  lane_ctl_t  ctl,
  input  lane_coef_t coef,
  input  sample_t    x_in,
  output sample_t    y
);

  sample_t x_r, x_nxt;
  sample_t prev_r, prev_nxt;
  sample_t held_r, held_nxt;
  sample_t crushed_r, crushed_nxt;

  logic signed [MUL_A_W-1:0]     mul_a;
  logic        [MUL_B_W-1:0]     mul_b;
  logic signed [PROD_W-1:0]      prod;
  logic signed [PROD_W-1:0]      rnd_sum;
  logic        [PROD_W-1:0]      r_sum;
  logic        [CRUSH_W-1:0]     r_val;
  logic        [SAMPLE_BITS-1:0] r_mag;
  logic        [QUANT_W-1:0]     q_val;
  logic signed [SAMPLE_BITS:0]   held_ext;
  logic signed [SAMPLE_BITS:0]   held_mag;
  logic signed [SAMPLE_BITS+1:0] rnd_wide;
  logic signed [SAMPLE_BITS+1:0] mix_sum;
  sample_t                       wet_src;
  sample_t                       interp_val;
  sample_t                       crush_val;

  sbcd_mul u_mul (
    .clk  (clk),
    .load (ctl.mul_load),
    .step (ctl.mul_step),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_comb begin
    held_ext = (SAMPLE_BITS+1)'(held_r);
    held_mag = held_r[SAMPLE_BITS-1] ? -held_ext : held_ext;
    q_val    = prod[LEVEL_SHIFT +: QUANT_W] + QUANT_W'(|prod[LEVEL_SHIFT-1:0]);
    wet_src  = ctl.quant ? crushed_r : held_r;
  end

  always_comb begin
    case (ctl.op)
      OP_INTERP: begin
        mul_a = MUL_A_W'(x_r) - MUL_A_W'(prev_r);
        mul_b = MUL_B_W'(coef.frac);
      end
      OP_LEVEL: begin
        mul_a = MUL_A_W'(held_mag);
        mul_b = MUL_B_W'(coef.levels);
      end
      OP_RECIP: begin
        mul_a = MUL_A_W'(q_val);
        mul_b = coef.recip;
      end
      OP_MIX: begin
        mul_a = MUL_A_W'(wet_src) - MUL_A_W'(x_r);
        mul_b = MUL_B_W'(coef.wet);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Interpolation and mix round half up; the crusher rounds the magnitude.
  always_comb begin
    rnd_sum    = prod + PROD_W'(ONE_Q16 / 2);
    interp_val = prev_r + sample_t'(rnd_sum[ROUND_SHIFT +: SAMPLE_BITS]);
    rnd_wide   = signed'(rnd_sum[ROUND_SHIFT +: SAMPLE_BITS+2]);
    mix_sum    = (SAMPLE_BITS+2)'(x_r) + rnd_wide;
    if (mix_sum > (SAMPLE_BITS+2)'(SAMPLE_MAX)) begin
      y = SAMPLE_MAX;
    end else if (mix_sum < -(SAMPLE_BITS+2)'(SAMPLE_MAX) - (SAMPLE_BITS+2)'(1)) begin
      y = sample_t'(MAG_LIMIT);
    end else begin
      y = sample_t'(mix_sum[SAMPLE_BITS-1:0]);
    end
  end

  always_comb begin
    r_sum = prod + PROD_W'(64'd1 << (RECIP_SHIFT - 1));
    r_val = r_sum[PROD_W-1:RECIP_SHIFT];
    r_mag = (r_val > CRUSH_W'(MAG_LIMIT)) ? MAG_LIMIT : r_val[SAMPLE_BITS-1:0];
    if (held_r[SAMPLE_BITS-1]) begin
      crush_val = sample_t'(-r_mag);
    end else if (r_mag[SAMPLE_BITS-1]) begin
      crush_val = SAMPLE_MAX;
    end else begin
      crush_val = sample_t'(r_mag);
    end
  end

  always_comb begin
    x_nxt       = ctl.x_load ? x_in : x_r;
    prev_nxt    = ctl.hold_wr ? x_r : prev_r;
    held_nxt    = (ctl.hold_wr && ctl.held_upd) ? interp_val : held_r;
    crushed_nxt = ctl.crush_wr ? crush_val : crushed_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      held_r <= '0;
    end else begin
      prev_r <= prev_nxt;
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    crushed_r <= crushed_nxt;
  end

endmodule

@@ src/stereo_bit_crusher_decimator.sv @@
`timescale 1ns / 1ps
// Stereo bit crusher with sample-rate reduction. Each accepted frame runs
// through interpolation when the phase accumulator reloads the held pair,
// the hold step, the crusher when quantization is enabled and the wet/dry
// mix. A new frame is accepted only once the last result has gone into the
// result register, which may wait for the result register to be taken.
// Each channel takes its products on a radix-4 serial multiplier: one for
// interpolation, two for the crusher and one for the wet/dry mix. Both
// channels run in lockstep. Depends on sbcd_pkg, sbcd_if, sbcd_regs and
// sbcd_lane.
module stereo_bit_crusher_decimator import sbcd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  sbcd_in_if.sink               in_chan,
  sbcd_out_if.source            out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t       cfg;
  seq_state_t state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [FRAC_W-1:0]  frac_r, frac_nxt;
  logic               reload_r, reload_nxt;
  logic               out_valid_r, out_valid_nxt;
  sample_t            out_left_r, out_left_nxt;
  sample_t            out_right_r, out_right_nxt;

  logic [PHASE_W-1:0] period;
  logic [PHASE_W:0]   phase_diff;
  logic [PHASE_W-1:0] phase_mid;
  logic [PHASE_W:0]   phase_inc;
  logic               reload;
  logic               in_ready;
  logic               accept;
  logic               mul_state;
  logic               mul_last;
  logic               out_free;
  logic               out_load;
  lane_ctl_t          ctl;
  lane_coef_t         coef;
  sample_t            y_left;
  sample_t            y_right;

  sbcd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Phase bookkeeping for the incoming frame.
  always_comb begin
    if (cfg.decim_period < PERIOD_MIN) begin
      period = PERIOD_MIN;
    end else if (cfg.decim_period > PERIOD_MAX) begin
      period = PERIOD_MAX;
    end else begin
      period = cfg.decim_period;
    end
    phase_diff = {1'b0, phase_r} - {1'b0, period};
    reload     = !phase_diff[PHASE_W];
    phase_mid  = reload ? phase_diff[PHASE_W-1:0] : phase_r;
    phase_inc  = {1'b0, phase_mid} + (PHASE_W+1)'(ONE_Q16);
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_ready && in_chan.valid;
  assign mul_state = state_r inside {ST_INTERP, ST_QLEVEL, ST_QRECIP, ST_MIX};
  assign mul_last  = mul_state && (cnt_r == CNT_W'(MUL_DIGITS));
  assign out_free  = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_chan.valid) state_nxt = reload ? ST_INTERP : ST_HOLD;
      ST_INTERP: if (mul_last) state_nxt = ST_HOLD;
      ST_HOLD:   state_nxt = cfg.quant_enable ? ST_QLEVEL : ST_MIX;
      ST_QLEVEL: if (mul_last) state_nxt = ST_QRECIP;
      ST_QRECIP: if (mul_last) state_nxt = ST_QFIN;
      ST_QFIN:   state_nxt = ST_MIX;
      ST_MIX:    if (mul_last) state_nxt = ST_OUT;
      ST_OUT:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.x_load   = accept;
    ctl.mul_load = mul_state && (cnt_r == '0);
    ctl.mul_step = mul_state && (cnt_r != '0);
    ctl.hold_wr  = (state_r == ST_HOLD);
    ctl.held_upd = reload_r;
    ctl.crush_wr = (state_r == ST_QFIN);
    ctl.quant    = cfg.quant_enable;
    out_load     = (state_r == ST_OUT) && out_free;
    case (state_r)
      ST_QLEVEL: ctl.op = OP_LEVEL;
      ST_QRECIP: ctl.op = OP_RECIP;
      ST_MIX:    ctl.op = OP_MIX;
      default:   ctl.op = OP_INTERP;
    endcase
  end

  always_comb begin
    cnt_nxt       = mul_state ? (mul_last ? '0 : cnt_r + CNT_W'(1)) : '0;
    phase_nxt     = phase_r;
    frac_nxt      = frac_r;
    reload_nxt    = reload_r;
    if (accept) begin
      phase_nxt  = phase_inc[PHASE_W] ? PHASE_SAT : phase_inc[PHASE_W-1:0];
      frac_nxt   = (phase_mid > PHASE_W'(FRAC_ONE)) ? FRAC_ONE : phase_mid[FRAC_W-1:0];
      reload_nxt = reload;
    end
    out_left_nxt  = out_load ? y_left : out_left_r;
    out_right_nxt = out_load ? y_right : out_right_r;
    out_valid_nxt = out_load || (out_valid_r && !out_chan.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      phase_r     <= '0;
      reload_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      phase_r     <= phase_nxt;
      reload_r    <= reload_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frac_r      <= frac_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
  end

  assign coef.frac   = frac_r;
  assign coef.wet    = (cfg.wet_mix > WET_W'(ONE_Q16)) ? WET_W'(ONE_Q16) : cfg.wet_mix;
  assign coef.levels = cfg.quant_levels;
  assign coef.recip  = cfg.quant_recip;

  sbcd_lane u_lane_left (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .coef  (coef),
    .x_in  (in_chan.in_left),
    .y     (y_left)
  );

  sbcd_lane u_lane_right (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .coef  (coef),
    .x_in  (in_chan.in_right),
    .y     (y_right)
  );

  assign in_chan.ready      = in_ready;
  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_left  = out_left_r;
  assign out_chan.out_right = out_right_r;

endmodule
